>>> design/gwer_pkg.sv
// shared constants and helpers for the grid wind to earth rotator
`default_nettype none
package gwer_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ATAN_LEN          = 24;

	localparam int LAT_W   = 24;
	localparam int LON_W   = 26;
	localparam int REFL_W  = 25;
	localparam int Q16_W   = 18;
	localparam int WIND_W  = 18;
	localparam int ANG_W   = 25;
	localparam int WRAP_W  = 32;
	localparam int XY_W    = 33;
	localparam int IN_W    = 88;
	localparam int OUT_W   = 40;
	localparam int CFG_W   = 25;

	localparam logic [1:0] REG_REF_LON  = 2'd0;
	localparam logic [1:0] REG_CONE     = 2'd1;
	localparam logic [1:0] REG_ROT_COS  = 2'd2;
	localparam logic [1:0] REG_ROT_SIN  = 2'd3;

	localparam logic signed [WRAP_W-1:0] FULL_TURN    = 32'sd23592960;
	localparam logic signed [WRAP_W-1:0] HALF_TURN    = 32'sd11796480;
	localparam logic signed [ANG_W-1:0]  QUARTER_TURN = 25'sd5898240;
	localparam logic signed [ANG_W-1:0]  HALF_TURN_A  = 25'sd11796480;
	localparam logic signed [LAT_W-1:0]  POLE_LIMIT   = 24'sd5832704;
	localparam logic signed [XY_W-1:0]   CORDIC_GAIN  = 33'sd652032875;
	localparam logic signed [Q16_W-1:0]  TRIG_ONE     = 18'sd65536;
	localparam logic signed [WIND_W-1:0] WIND_MAX     = 18'sd131071;

	typedef logic signed [ANG_W-1:0] ang_t;

	// arctangent of 2^-i in degrees * 2^16
	function automatic ang_t atan_deg(input int i);
		ang_t r;
		unique case (i)
			0: r = 25'sd2949120;   1: r = 25'sd1740967;   2: r = 25'sd919879;
			3: r = 25'sd466945;    4: r = 25'sd234379;    5: r = 25'sd117304;
			6: r = 25'sd58666;     7: r = 25'sd29335;     8: r = 25'sd14668;
			9: r = 25'sd7334;      10: r = 25'sd3667;     11: r = 25'sd1833;
			12: r = 25'sd917;      13: r = 25'sd458;      14: r = 25'sd229;
			15: r = 25'sd115;      16: r = 25'sd57;       17: r = 25'sd29;
			18: r = 25'sd14;       19: r = 25'sd7;        20: r = 25'sd4;
			21: r = 25'sd2;        22: r = 25'sd1;        default: r = 25'sd0;
		endcase
		return r;
	endfunction

	// reduce into [-180,180) degrees; input spans at most four turns each way
	function automatic ang_t wrap_half(input logic signed [WRAP_W-1:0] v);
		logic signed [WRAP_W+3:0] cand;
		ang_t r;
		r = '0;
		for (int k = -4; k <= 4; k++) begin
			cand = 36'(v) - 36'(k) * 36'(FULL_TURN);
			if (cand >= 36'(-HALF_TURN) && cand < 36'(HALF_TURN))
				r = cand[ANG_W-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> design/grid_wind_to_earth_rotator.sv
// throughput: one word per cycle unless the output stalls; one CORDIC iteration per pipeline stage
// the whole pipeline holds while an output word waits and tready is low
// arst_n clears valid bits and loads the register defaults (rotate_cos = 1.0)
// pipeline data registers are not reset
`default_nettype none
module grid_wind_to_earth_rotator #(
	parameter int CORDIC_STAGES = gwer_pkg::CORDIC_STAGES_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_axis_tvalid,
	output logic                             s_axis_tready,
	// latitude[23:0], longitude[49:24], wind_grid_u[67:50], wind_grid_v[85:68], zero pad
	input  wire logic [gwer_pkg::IN_W-1:0]   s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	// wind_east[17:0], wind_north[35:18], zero pad
	output logic [gwer_pkg::OUT_W-1:0]       m_axis_tdata,
	input  wire logic                        cfg_we,
	input  wire logic [1:0]                  cfg_idx,
	input  wire logic [gwer_pkg::CFG_W-1:0]  cfg_data
);
	localparam int N = (CORDIC_STAGES > gwer_pkg::ATAN_LEN) ? gwer_pkg::ATAN_LEN : CORDIC_STAGES;
	localparam int XY = gwer_pkg::XY_W;
	localparam int AW = gwer_pkg::ANG_W;

	logic signed [24:0] ref_lon_q;
	logic signed [17:0] cone_q, rot_cos_q, rot_sin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_lon_q <= '0;
			cone_q    <= '0;
			rot_cos_q <= gwer_pkg::TRIG_ONE;
			rot_sin_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				gwer_pkg::REG_REF_LON: ref_lon_q <= cfg_data;
				gwer_pkg::REG_CONE:    cone_q    <= cfg_data[17:0];
				gwer_pkg::REG_ROT_COS: rot_cos_q <= cfg_data[17:0];
				gwer_pkg::REG_ROT_SIN: rot_sin_q <= cfg_data[17:0];
				default: ;
			endcase
		end
	end

	logic en;
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	logic signed [23:0] lat_in;
	logic signed [25:0] lon_in;
	logic signed [17:0] u_in, v_in;
	assign lat_in = s_axis_tdata[23:0];
	assign lon_in = s_axis_tdata[49:24];
	assign u_in   = s_axis_tdata[67:50];
	assign v_in   = s_axis_tdata[85:68];

	// stage 1: longitude offset wrapped
	logic              vld_s1, pn_s1, ps_s1;
	logic signed [AW-1:0] off_s1;
	logic signed [25:0] lon_s1;
	logic signed [17:0] u_s1, v_s1;
	// stage 2: cone product
	logic              vld_s2, pn_s2, ps_s2;
	logic signed [42:0] prod_s2;
	logic signed [25:0] lon_s2;
	logic signed [17:0] u_s2, v_s2;
	// stage 3: angle in [-180,180)
	logic              vld_s3;
	logic signed [AW-1:0] ang_s3;
	logic signed [17:0] u_s3, v_s3;
	// cordic pipe, index 0 is the folded angle
	logic              cv_s  [N+1];
	logic              cneg_s[N+1];
	logic signed [XY-1:0] cx_s[N+1];
	logic signed [XY-1:0] cy_s[N+1];
	logic signed [AW-1:0] cz_s[N+1];
	logic signed [17:0] cu_s[N+1];
	logic signed [17:0] cw_s[N+1];
	// stage 5 .. 9
	logic              vld_s5, vld_s6, vld_s7, vld_s8;
	logic signed [17:0] sn_s5, cs_s5, u_s5, v_s5, u_s6, v_s6, u_s7, v_s7;
	logic signed [35:0] sc_s6, cs_s6, cc_s6, ss_s6;
	logic signed [36:0] xp_s7, yp_s7;
	logic signed [54:0] yu_s8, xv_s8, yv_s8, xu_s8;

	logic signed [26:0] diff;
	logic signed [43:0] nprod;
	logic signed [27:0] rang;
	logic signed [28:0] asum;
	logic signed [18:0] xr, yr;
	logic signed [17:0] xc, yc;
	logic signed [55:0] esum, nsum;
	logic signed [23:0] er, nr;
	logic signed [17:0] ec, nc;

	always_comb begin
		diff  = 27'(lon_in) - 27'(ref_lon_q);
		nprod = -44'(prod_s2) + 44'sd32768;
		rang  = nprod[43:16];
		if (pn_s2)
			asum = 29'(rang) + 29'(lon_s2) - 29'(gwer_pkg::HALF_TURN);
		else if (ps_s2)
			asum = 29'(rang) - 29'(lon_s2);
		else
			asum = 29'(rang);
		xr = 19'((cx_s[N] + 33'sd8192) >>> 14);
		yr = 19'((cy_s[N] + 33'sd8192) >>> 14);
		if (xr > 19'(gwer_pkg::TRIG_ONE))       xc = gwer_pkg::TRIG_ONE;
		else if (xr < -19'(gwer_pkg::TRIG_ONE)) xc = -gwer_pkg::TRIG_ONE;
		else                                    xc = xr[17:0];
		if (yr > 19'(gwer_pkg::TRIG_ONE))       yc = gwer_pkg::TRIG_ONE;
		else if (yr < -19'(gwer_pkg::TRIG_ONE)) yc = -gwer_pkg::TRIG_ONE;
		else                                    yc = yr[17:0];
		esum = 56'(yu_s8) - 56'(xv_s8) + 56'sh80000000;
		nsum = 56'(yv_s8) + 56'(xu_s8) + 56'sh80000000;
		er = esum[55:32];
		nr = nsum[55:32];
		if (er > 24'(gwer_pkg::WIND_MAX))       ec = gwer_pkg::WIND_MAX;
		else if (er < -24'(gwer_pkg::WIND_MAX)) ec = -gwer_pkg::WIND_MAX;
		else                                    ec = er[17:0];
		if (nr > 24'(gwer_pkg::WIND_MAX))       nc = gwer_pkg::WIND_MAX;
		else if (nr < -24'(gwer_pkg::WIND_MAX)) nc = -gwer_pkg::WIND_MAX;
		else                                    nc = nr[17:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			m_axis_tvalid <= 1'b0;
			for (int i = 0; i <= N; i++) cv_s[i] <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_axis_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			cv_s[0] <= vld_s3;
			for (int i = 1; i <= N; i++) cv_s[i] <= cv_s[i-1];
			vld_s5 <= cv_s[N];
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			m_axis_tvalid <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			off_s1 <= gwer_pkg::wrap_half(32'(diff));
			pn_s1  <= lat_in > gwer_pkg::POLE_LIMIT;
			ps_s1  <= lat_in < -gwer_pkg::POLE_LIMIT;
			lon_s1 <= lon_in;
			u_s1   <= u_in;
			v_s1   <= v_in;

			prod_s2 <= 43'(cone_q) * 43'(off_s1);
			pn_s2   <= pn_s1;
			ps_s2   <= ps_s1;
			lon_s2  <= lon_s1;
			u_s2    <= u_s1;
			v_s2    <= v_s1;

			ang_s3 <= gwer_pkg::wrap_half(32'(asum));
			u_s3   <= u_s2;
			v_s3   <= v_s2;

			// fold into [-90,90], sign restored after the cordic
			if (ang_s3 > gwer_pkg::QUARTER_TURN) begin
				cz_s[0]   <= ang_s3 - gwer_pkg::HALF_TURN_A;
				cneg_s[0] <= 1'b1;
			end else if (ang_s3 < -gwer_pkg::QUARTER_TURN) begin
				cz_s[0]   <= ang_s3 + gwer_pkg::HALF_TURN_A;
				cneg_s[0] <= 1'b1;
			end else begin
				cz_s[0]   <= ang_s3;
				cneg_s[0] <= 1'b0;
			end
			cx_s[0] <= gwer_pkg::CORDIC_GAIN;
			cy_s[0] <= '0;
			cu_s[0] <= u_s3;
			cw_s[0] <= v_s3;

			for (int i = 0; i < N; i++) begin
				if (!cz_s[i][AW-1]) begin
					cx_s[i+1] <= cx_s[i] - (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] + (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] - gwer_pkg::atan_deg(i);
				end else begin
					cx_s[i+1] <= cx_s[i] + (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] - (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] + gwer_pkg::atan_deg(i);
				end
				cneg_s[i+1] <= cneg_s[i];
				cu_s[i+1]   <= cu_s[i];
				cw_s[i+1]   <= cw_s[i];
			end

			sn_s5 <= cneg_s[N] ? -yc : yc;
			cs_s5 <= cneg_s[N] ? -xc : xc;
			u_s5  <= cu_s[N];
			v_s5  <= cw_s[N];

			sc_s6 <= 36'(sn_s5) * 36'(rot_cos_q);
			cs_s6 <= 36'(cs_s5) * 36'(rot_sin_q);
			cc_s6 <= 36'(cs_s5) * 36'(rot_cos_q);
			ss_s6 <= 36'(sn_s5) * 36'(rot_sin_q);
			u_s6  <= u_s5;
			v_s6  <= v_s5;

			xp_s7 <= 37'(sc_s6) + 37'(cs_s6);
			yp_s7 <= 37'(cc_s6) - 37'(ss_s6);
			u_s7  <= u_s6;
			v_s7  <= v_s6;

			yu_s8 <= 55'(yp_s7) * 55'(u_s7);
			xv_s8 <= 55'(xp_s7) * 55'(v_s7);
			yv_s8 <= 55'(yp_s7) * 55'(v_s7);
			xu_s8 <= 55'(xp_s7) * 55'(u_s7);

			m_axis_tdata <= {4'b0, nc, ec};
		end
	end

endmodule
`default_nettype wire

>>> design/gwer_checker.sv
// port-level checker for the grid wind to earth rotator, bound to the top level
`default_nettype none
module gwer_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [39:0] m_axis_tdata
);
	// a waiting output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word dropped or changed while stalled");

	// input side only stalls behind a waiting output word
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

	// saturated outputs never reach the most negative code
	a_east_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[17:0] != 18'h20000)
		else $error("wind_east outside saturation range");

	a_north_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[35:18] != 18'h20000)
		else $error("wind_north outside saturation range");

endmodule

bind grid_wind_to_earth_rotator gwer_checker u_gwer_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
